>>> design/cds_pkg.sv
// Shared types and constants for the critically damped 3D smoother.
package cds_pkg;

    typedef struct packed {
        logic signed [31:0] current_x;
        logic signed [31:0] current_y;
        logic signed [31:0] current_z;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
        logic [20:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               snapped;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic         done;
        logic         neg;
        logic [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [63:0] root;
    } t_sqrt_rsp;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 1'd1;

    localparam logic [30:0] ST_RESET = 31'd65536;
    localparam logic [30:0] MS_RESET = 31'h7FFF_FFFF;
    localparam logic [30:0] ST_MIN   = 31'd7;

    localparam logic [63:0] LIM_U = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [23:0] XMAX  = 24'hFF_FFFF;
    localparam logic [14:0] C048  = 15'd31457;
    localparam logic [13:0] C0235 = 14'd15401;

endpackage

>>> design/cds_mul.sv
// Multi-cycle 64x64 magnitude multiplier built from one 32x32 multiplier.
module cds_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cds_pkg::t_mul_req i_req,
    output cds_pkg::t_mul_rsp o_rsp
);
    import cds_pkg::*;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_neg;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic         r_ppv;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] pp_aligned;
    logic [63:0]  a_mag;
    logic [63:0]  b_mag;

    assign a_mag  = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
    assign b_mag  = i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
    assign a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_sh)
            2'd0:    pp_aligned = {64'd0, r_pp};
            2'd1:    pp_aligned = {32'd0, r_pp, 32'd0};
            2'd2:    pp_aligned = {r_pp, 64'd0};
            default: pp_aligned = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= a_mag;
                r_b    <= b_mag;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_cnt  <= '0;
                r_acc  <= '0;
                r_ppv  <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // One partial product is formed while the previous one is added.
                if (r_cnt != 3'd4) begin
                    r_pp  <= 64'(a_part) * 64'(b_part);
                    r_sh  <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                    r_ppv <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_ppv  <= 1'b0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                if (r_ppv) begin
                    r_acc <= r_acc + pp_aligned;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_neg;
    assign o_rsp.prod = r_acc;

endmodule

>>> design/cds_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit operands.
module cds_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cds_pkg::t_div_req i_req,
    output cds_pkg::t_div_rsp o_rsp
);
    import cds_pkg::*;

    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] trial;
    logic        fits;

    assign trial = {r_rem, r_quo[63]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? 64'(trial - {1'b0, r_den}) : trial[63:0];
                r_quo <= {r_quo[62:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> design/cds_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module cds_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cds_pkg::t_sqrt_req i_req,
    output cds_pkg::t_sqrt_rsp o_rsp
);
    import cds_pkg::*;

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [63:0] trial;
    logic        fits;

    assign trial = r_res + r_bit;
    assign fits  = r_v >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_v    <= i_req.value;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res;

endmodule

>>> design/critically_damped_smoother_3d.sv
// Top level: sequencer and datapath of the critically damped 3D smoother.
//
// Input requests carry current and goal positions (Q16.16) plus a time step (UQ5.16).
// A request is taken when i_in_valid is high and o_in_stall is low; the block
// then works on it alone, holding o_in_stall high until the result is formed.
// Each request gives exactly one result on the output channel, which is taken
// when o_out_valid is high and i_out_stall is low. The result sits in an
// output register, so a new request is taken while a result still waits.
// The request is worked through on the shared units: a 64-step divider (two or
// three divisions), a 32-step square root when the error length is limited,
// and a 32x32 multiplier that forms each 64x64 product in four partial
// products (27 to 31 products). The next request can be taken in the cycle
// after the result is loaded into the output register, once the sequencer
// has returned to idle.
// A synchronous active-low reset clears the velocity to zero, loads the
// register reset values and empties the output register. While the receiver
// stalls, the result holds; a finished request waits in its last step until
// the output register frees up. Configuration writes are always accepted
// and must only be issued while the block is idle.
module critically_damped_smoother_3d (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  cds_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output cds_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import cds_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_OMEGA = 5'd1;
    localparam logic [4:0] S_XM    = 5'd2;
    localparam logic [4:0] S_X2    = 5'd3;
    localparam logic [4:0] S_X3    = 5'd4;
    localparam logic [4:0] S_T2    = 5'd5;
    localparam logic [4:0] S_T3    = 5'd6;
    localparam logic [4:0] S_EX    = 5'd7;
    localparam logic [4:0] S_MC    = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_MCSQ  = 5'd10;
    localparam logic [4:0] S_SQRT  = 5'd11;
    localparam logic [4:0] S_RDIV  = 5'd12;
    localparam logic [4:0] S_LIM   = 5'd13;
    localparam logic [4:0] S_P1    = 5'd14;
    localparam logic [4:0] S_TMP   = 5'd15;
    localparam logic [4:0] S_P2    = 5'd16;
    localparam logic [4:0] S_NV    = 5'd17;
    localparam logic [4:0] S_P3    = 5'd18;
    localparam logic [4:0] S_DOT   = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] r;
        r = 65'(a) + 65'(b);
        if (r > LIM65) begin
            r = LIM65;
        end else if (r < -LIM65) begin
            r = -LIM65;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] f_smul(input logic [127:0] p, input logic n,
                                                  input logic sel32);
        logic [127:0] sh;
        logic [63:0]  rl;
        sh = sel32 ? (p >> 32) : (p >> 16);
        rl = (sh[127:64] != '0 || sh[63:0] > LIM_U) ? LIM_U : sh[63:0];
        return n ? -$signed(rl) : $signed(rl);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    logic [4:0]         r_state;
    logic               r_launch;
    logic [1:0]         r_axis;
    logic [30:0]        r_smooth_time;
    logic [30:0]        r_max_speed;
    logic [30:0]        r_st;
    logic [20:0]        r_dt;
    logic [30:0]        r_omega;
    logic [23:0]        r_x;
    logic [31:0]        r_x2;
    logic [39:0]        r_x3;
    logic [39:0]        r_den;
    logic [32:0]        r_ex;
    logic [43:0]        r_mc2;
    logic [63:0]        r_sum;
    logic [31:0]        r_mag;
    logic [32:0]        r_r;
    logic signed [31:0] r_cur  [3];
    logic signed [31:0] r_goal [3];
    logic signed [33:0] r_ch   [3];
    logic signed [31:0] r_vel  [3];
    logic signed [63:0] r_o    [3];
    logic signed [63:0] r_acc;
    logic signed [63:0] r_tmp;
    logic signed [63:0] r_dot;
    logic               r_out_valid;
    t_out_item          r_out;

    t_mul_req  mul_req;
    t_mul_rsp  mul_rsp;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;

    logic [32:0]        ch_mag;
    logic               mc2_wide;
    logic               unit_done;
    logic signed [63:0] smul16;
    logic signed [63:0] smul32;
    logic               snap;
    logic [30:0]        st_next;

    cds_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    cds_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    cds_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sqrt_req), .o_rsp(sqrt_rsp));

    assign ch_mag    = r_ch[r_axis][33] ? 33'(-r_ch[r_axis]) : 33'(r_ch[r_axis]);
    assign mc2_wide  = r_mc2[43:32] != '0;
    assign unit_done = mul_rsp.done || div_rsp.done || sqrt_rsp.done;
    assign smul16    = f_smul(mul_rsp.prod, mul_rsp.neg, 1'b0);
    assign smul32    = f_smul(mul_rsp.prod, mul_rsp.neg, 1'b1);
    assign snap      = r_dot > 64'sd0;
    assign st_next   = (r_smooth_time < ST_MIN) ? ST_MIN : r_smooth_time;

    // Operand selection for the shared units.
    always_comb begin
        mul_req.start = r_launch && (r_state inside {S_XM, S_X2, S_X3, S_T2, S_T3, S_MC,
                        S_SQ, S_LIM, S_P1, S_TMP, S_P2, S_NV, S_P3, S_DOT}
                        || (r_state == S_MCSQ && !mc2_wide));
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_state)
            S_XM:    begin mul_req.a = 64'(r_omega); mul_req.b = 64'(r_dt); end
            S_X2:    begin mul_req.a = 64'(r_x);     mul_req.b = 64'(r_x); end
            S_X3:    begin mul_req.a = 64'(r_x2);    mul_req.b = 64'(r_x); end
            S_T2:    begin mul_req.a = 64'(C048);    mul_req.b = 64'(r_x2); end
            S_T3:    begin mul_req.a = 64'(C0235);   mul_req.b = 64'(r_x3); end
            S_MC:    begin mul_req.a = 64'(r_max_speed); mul_req.b = 64'(r_st); end
            S_SQ:    begin mul_req.a = 64'(ch_mag >> 2); mul_req.b = 64'(ch_mag >> 2); end
            S_MCSQ:  begin mul_req.a = 64'(r_mc2);   mul_req.b = 64'(r_mc2); end
            S_LIM:   begin mul_req.a = 64'(ch_mag);  mul_req.b = 64'(r_r); end
            S_P1:    begin mul_req.a = 64'(r_omega); mul_req.b = 64'(r_ch[r_axis]); end
            S_TMP:   begin mul_req.a = r_acc;        mul_req.b = 64'(r_dt); end
            S_P2:    begin mul_req.a = 64'(r_omega); mul_req.b = r_tmp; end
            S_NV:    begin mul_req.a = r_acc;        mul_req.b = 64'(r_ex); end
            S_P3:    begin
                mul_req.a = f_sadd(64'(r_ch[r_axis]), r_tmp);
                mul_req.b = 64'(r_ex);
            end
            S_DOT:   begin
                mul_req.a = 64'(r_goal[r_axis]) - 64'(r_cur[r_axis]);
                mul_req.b = r_o[r_axis] - 64'(r_goal[r_axis]);
            end
            default: begin mul_req.a = '0; mul_req.b = '0; end
        endcase
    end

    always_comb begin
        div_req.start = r_launch && (r_state inside {S_OMEGA, S_EX, S_RDIV});
        case (r_state)
            S_OMEGA: begin div_req.num = 64'd1 << 33; div_req.den = 64'(r_st); end
            S_EX:    begin div_req.num = 64'd1 << 48; div_req.den = 64'(r_den); end
            S_RDIV:  begin div_req.num = {r_mc2[31:0], 32'd0}; div_req.den = 64'(r_mag); end
            default: begin div_req.num = '0; div_req.den = '0; end
        endcase
        sqrt_req.start = r_launch && r_state == S_SQRT;
        sqrt_req.value = r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_launch      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_smooth_time <= ST_RESET;
            r_max_speed   <= MS_RESET;
            r_vel         <= '{default: '0};
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SMOOTH_TIME: r_smooth_time <= i_cfg_data[30:0];
                    CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cur[0]  <= i_in.current_x;
                        r_cur[1]  <= i_in.current_y;
                        r_cur[2]  <= i_in.current_z;
                        r_goal[0] <= i_in.goal_x;
                        r_goal[1] <= i_in.goal_y;
                        r_goal[2] <= i_in.goal_z;
                        r_ch[0]   <= 34'(i_in.current_x) - 34'(i_in.goal_x);
                        r_ch[1]   <= 34'(i_in.current_y) - 34'(i_in.goal_y);
                        r_ch[2]   <= 34'(i_in.current_z) - 34'(i_in.goal_z);
                        r_dt      <= i_in.time_step;
                        r_st      <= st_next;
                        r_sum     <= '0;
                        r_dot     <= '0;
                        r_axis    <= '0;
                        r_state   <= S_OMEGA;
                        r_launch  <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.out_x   <= snap ? r_goal[0] : f_sat32(r_o[0]);
                        r_out.out_y   <= snap ? r_goal[1] : f_sat32(r_o[1]);
                        r_out.out_z   <= snap ? r_goal[2] : f_sat32(r_o[2]);
                        r_out.snapped <= snap;
                        if (snap) begin
                            r_vel <= '{default: '0};
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    if (r_launch) begin
                        r_launch <= 1'b0;
                        // A limit too large to square can never be exceeded.
                        if (r_state == S_MCSQ && mc2_wide) begin
                            r_state  <= S_P1;
                            r_launch <= 1'b1;
                        end
                    end else if (unit_done) begin
                        r_launch <= 1'b1;
                        case (r_state)
                            S_OMEGA: begin
                                r_omega <= div_rsp.quo[30:0];
                                r_state <= S_XM;
                            end
                            S_XM: begin
                                r_x <= (mul_rsp.prod[127:16] > 112'(XMAX)) ? XMAX
                                       : mul_rsp.prod[39:16];
                                r_state <= S_X2;
                            end
                            S_X2: begin
                                r_x2    <= mul_rsp.prod[47:16];
                                r_state <= S_X3;
                            end
                            S_X3: begin
                                r_x3    <= mul_rsp.prod[55:16];
                                r_state <= S_T2;
                            end
                            S_T2: begin
                                r_den   <= 40'd65536 + 40'(r_x) + 40'(mul_rsp.prod[46:16]);
                                r_state <= S_T3;
                            end
                            S_T3: begin
                                r_den   <= r_den + 40'(mul_rsp.prod[53:16]);
                                r_state <= S_EX;
                            end
                            S_EX: begin
                                r_ex    <= div_rsp.quo[32:0];
                                r_state <= S_MC;
                            end
                            S_MC: begin
                                r_mc2   <= mul_rsp.prod[61:18];
                                r_state <= S_SQ;
                            end
                            S_SQ: begin
                                r_sum <= r_sum + mul_rsp.prod[63:0];
                                if (r_axis == 2'd2) begin
                                    r_axis  <= '0;
                                    r_state <= S_MCSQ;
                                end else begin
                                    r_axis <= r_axis + 2'd1;
                                end
                            end
                            S_MCSQ: begin
                                r_state <= (r_sum > mul_rsp.prod[63:0]) ? S_SQRT : S_P1;
                            end
                            S_SQRT: begin
                                r_mag   <= sqrt_rsp.root[31:0];
                                r_state <= S_RDIV;
                            end
                            S_RDIV: begin
                                r_r     <= div_rsp.quo[32:0];
                                r_state <= S_LIM;
                            end
                            S_LIM: begin
                                r_ch[r_axis] <= r_ch[r_axis][33] ?
                                                -34'(mul_rsp.prod[64:32]) :
                                                34'(mul_rsp.prod[64:32]);
                                if (r_axis == 2'd2) begin
                                    r_axis  <= '0;
                                    r_state <= S_P1;
                                end else begin
                                    r_axis <= r_axis + 2'd1;
                                end
                            end
                            S_P1: begin
                                r_acc   <= f_sadd(64'(r_vel[r_axis]), smul16);
                                r_state <= S_TMP;
                            end
                            S_TMP: begin
                                r_tmp   <= smul16;
                                r_state <= S_P2;
                            end
                            S_P2: begin
                                r_acc   <= f_sadd(64'(r_vel[r_axis]), -smul16);
                                r_state <= S_NV;
                            end
                            S_NV: begin
                                r_vel[r_axis] <= f_sat32(smul32);
                                r_state       <= S_P3;
                            end
                            S_P3: begin
                                r_o[r_axis] <= f_sadd(64'(r_cur[r_axis]) - 64'(r_ch[r_axis]),
                                                      smul32);
                                r_state     <= S_DOT;
                            end
                            S_DOT: begin
                                r_dot <= f_sadd(r_dot, smul16);
                                if (r_axis == 2'd2) begin
                                    r_axis   <= '0;
                                    r_launch <= 1'b0;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_axis  <= r_axis + 2'd1;
                                    r_state <= S_P1;
                                end
                            end
                            default: begin
                                r_launch <= 1'b0;
                                r_state  <= S_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTH
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took a request but did not start working on it");

    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !unit_done)
        else $error("shared unit finished while the sequencer was idle");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result appeared without the sequencer finishing a request");
`endif

endmodule

>>> sim/critically_damped_smoother_3d_test.sv
// Self-checking testbench for the critically damped 3D smoother.
module critically_damped_smoother_3d_test;
    import cds_pkg::*;

    localparam int        CYCLE_LIMIT = 8000000;
    localparam int        HOLD_CYCLES = 3000;
    localparam int        TAIL_CYCLES = 600;
    localparam longint    SAT_LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    critically_damped_smoother_3d u_top (.*);

    // Shadow state of the block.
    longint unsigned smooth_time_q;
    longint unsigned max_speed_q;
    longint          vel[3];
    t_out_item       last_out;
    t_out_item       expected_q[$];

    int         mismatches;
    int         cycles;
    t_idle_mode idle_mode;
    bit         hold_arm;
    int         hold_left;
    longint     aim[3];
    t_dir_row   dir_rows[$];

    always #6 i_clk = ~i_clk;

    function automatic longint unsigned mag_of(longint a);
        return a < 0 ? longint'(-a) : longint'(a);
    endfunction

    // Exact product, magnitude shifted toward zero and saturated.
    function automatic longint mul_shift(longint a, longint b, int s);
        logic [127:0]    p;
        longint unsigned rl;
        bit              neg;
        neg = (a < 0) != (b < 0);
        p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
        p = p >> s;
        rl = (p > 128'(SAT_LIM)) ? SAT_LIM : p[63:0];
        return neg ? -longint'(rl) : longint'(rl);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint r;
        r = a + b;
        if (r > SAT_LIM) r = SAT_LIM;
        if (r < -SAT_LIM) r = -SAT_LIM;
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // One spring step; updates the shadow velocity.
    function automatic t_out_item smooth_step(t_in_item it);
        longint          cur[3], goal[3], chg[3], o[3];
        longint unsigned st, omega, dt, x, x2, x3, den, ex, mc, mc2, sq, a, mag, r, m;
        longint          dot, tgt, tmp, nv;
        bit              snap;
        t_out_item       res;
        cur[0] = it.current_x; cur[1] = it.current_y; cur[2] = it.current_z;
        goal[0] = it.goal_x;   goal[1] = it.goal_y;   goal[2] = it.goal_z;
        for (int i = 0; i < 3; i++) chg[i] = cur[i] - goal[i];
        dt = it.time_step;
        st = smooth_time_q < 7 ? 7 : smooth_time_q;
        omega = (64'd1 << 33) / st;
        x = (omega * dt) >> 16;
        if (x > 64'(XMAX)) x = 64'(XMAX);
        x2 = (x * x) >> 16;
        x3 = (x2 * x) >> 16;
        den = 65536 + x + ((64'(C048) * x2) >> 16) + ((64'(C0235) * x3) >> 16);
        ex = (64'd1 << 48) / den;
        mc = (max_speed_q * st) >> 16;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            a = mag_of(chg[i]) >> 2;
            sq += a * a;
        end
        mc2 = mc >> 2;
        // Clamp the error vector to the maximum change length.
        if (mc2 < (64'd1 << 32) && sq > mc2 * mc2) begin
            mag = int_sqrt(sq);
            r = (mc2 << 32) / mag;
            for (int i = 0; i < 3; i++) begin
                m = (mag_of(chg[i]) * r) >> 32;
                chg[i] = chg[i] < 0 ? -longint'(m) : longint'(m);
            end
        end
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            tgt = cur[i] - chg[i];
            tmp = mul_shift(add_sat(vel[i], mul_shift(longint'(omega), chg[i], 16)),
                            longint'(dt), 16);
            nv = mul_shift(add_sat(vel[i], -mul_shift(longint'(omega), tmp, 16)),
                           longint'(ex), 32);
            vel[i] = clamp32(nv);
            o[i] = add_sat(tgt, mul_shift(add_sat(chg[i], tmp), longint'(ex), 32));
            dot = add_sat(dot, mul_shift(goal[i] - cur[i], o[i] - goal[i], 16));
        end
        snap = dot > 0;
        for (int i = 0; i < 3; i++) begin
            if (snap) begin
                o[i] = goal[i];
                vel[i] = 0;
            end else begin
                o[i] = clamp32(o[i]);
            end
        end
        res.out_x = o[0][31:0];
        res.out_y = o[1][31:0];
        res.out_z = o[2][31:0];
        res.snapped = snap;
        return res;
    endfunction

    function automatic t_in_item make_req(longint cx, longint cy, longint cz,
                                          longint gx, longint gy, longint gz,
                                          longint unsigned dt);
        t_in_item it;
        it.current_x = cx[31:0]; it.current_y = cy[31:0]; it.current_z = cz[31:0];
        it.goal_x = gx[31:0];    it.goal_y = gy[31:0];    it.goal_z = gz[31:0];
        it.time_step = dt[20:0];
        return it;
    endfunction

    function automatic t_out_item make_res(longint x, longint y, longint z, bit snap);
        t_out_item r;
        r.out_x = x[31:0]; r.out_y = y[31:0]; r.out_z = z[31:0]; r.snapped = snap;
        return r;
    endfunction

    function automatic longint rand_pos(int kind);
        case (kind)
            0: return longint'(signed'($urandom()));
            1: return $urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
            default: return longint'($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    // Random request: mostly a tracking sequence fed with the last output.
    function automatic t_in_item next_req();
        longint          c[3];
        longint unsigned dt;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(0, 9) == 0)
                    aim[i] = rand_pos($urandom_range(0, 9) == 0 ? 0 : 2) * 16;
                aim[i] = clamp32(aim[i] + longint'($urandom_range(0, 20000)) - 10000);
            end
            c[0] = last_out.out_x; c[1] = last_out.out_y; c[2] = last_out.out_z;
        end else begin
            for (int i = 0; i < 3; i++) begin
                c[i] = rand_pos($urandom_range(0, 4));
                aim[i] = rand_pos($urandom_range(0, 4));
            end
        end
        case ($urandom_range(0, 9))
            0:       dt = $urandom_range(0, 21'h1F_FFFF);
            1:       dt = $urandom_range(0, 1048576);
            2:       dt = $urandom_range(0, 16);
            default: dt = $urandom_range(500, 4000);
        endcase
        return make_req(c[0], c[1], c[2], aim[0], aim[1], aim[2], dt);
    endfunction

    task automatic send_req(t_in_item it, bit typed, t_out_item want);
        t_out_item got;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(0, 99) < (idle_mode == IDLE_SEND ? 47 : 9)) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        got = smooth_step(it);
        last_out = got;
        expected_q.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    task automatic set_config(longint unsigned st, longint unsigned ms);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SMOOTH_TIME;
        i_cfg_data <= st[31:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        smooth_time_q = st & 64'h7FFF_FFFF;
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_SPEED;
        i_cfg_data <= ms[31:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        max_speed_q = ms & 64'h7FFF_FFFF;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Receiver: random stalls by phase, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (idle_mode == IDLE_RECV) begin
            i_out_stall <= $urandom_range(0, 99) < 47;
        end else if (idle_mode == IDLE_BOTH) begin
            i_out_stall <= $urandom_range(0, 99) < 9;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result x=%h y=%h z=%h snapped=%b",
                             o_out.out_x, o_out.out_y, o_out.out_z, o_out.snapped);
            end else begin
                want = expected_q.pop_front();
                if (o_out.out_x !== want.out_x || o_out.out_y !== want.out_y ||
                    o_out.out_z !== want.out_z || o_out.snapped !== want.snapped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: want x=%h y=%h z=%h s=%b, got x=%h y=%h z=%h s=%b",
                                 want.out_x, want.out_y, want.out_z, want.snapped,
                                 o_out.out_x, o_out.out_y, o_out.out_z, o_out.snapped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** critically_damped_smoother_3d: FAILED **");
            $finish;
        end
    end

    initial begin
        longint unsigned phase_st[7];
        longint unsigned phase_ms[7];
        t_out_item dummy;
        phase_st = '{65536, 0, 64'h7FFF_FFFF, 32768, 65536, 1, 7};
        phase_ms = '{64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                     262144, 0, 1, 64'h4000_0000};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SMOOTH_TIME;
        i_cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        idle_mode = IDLE_NONE;
        hold_arm = 1'b0;
        hold_left = 0;
        smooth_time_q = 64'(ST_RESET);
        max_speed_q = 64'(MS_RESET);
        vel = '{0, 0, 0};
        aim = '{0, 0, 0};
        last_out = '0;
        dummy = '0;

        // Matched current and goal with no velocity stay put, then three requests head for one goal.
        dir_rows.push_back('{make_req(0, 0, 0, 0, 0, 0, 1), 1, make_res(0, 0, 0, 0)});
        dir_rows.push_back('{make_req(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                                      64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0), 1,
                             make_res(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0)});
        dir_rows.push_back('{make_req(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                                      -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                                      21'h1F_FFFF), 1,
                             make_res(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 0)});
        dir_rows.push_back('{make_req(0, 0, 0, 655360, -655360, 65536, 1092), 0, dummy});
        dir_rows.push_back('{make_req(1000, 2000, 3000, 655360, -655360, 65536, 1092), 0, dummy});
        dir_rows.push_back('{make_req(5000, 9000, 1000, 655360, -655360, 65536, 0), 0, dummy});
        // Errors long enough to be clamped in length.
        dir_rows.push_back('{make_req(64'sh7FFF_FFFF, -64'sh8000_0000, 0,
                                      -64'sh8000_0000, 64'sh7FFF_FFFF, 0, 1092), 0, dummy});
        dir_rows.push_back('{make_req(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                                      64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000,
                                      1048576), 0, dummy});
        dir_rows.push_back('{make_req(64'sh5555_5555, 64'shAAAA_AAAA, 64'sh5555_5555,
                                      64'shAAAA_AAAA, 64'sh5555_5555, 64'shAAAA_AAAA,
                                      21'h15_5555), 0, dummy});
        dir_rows.push_back('{make_req(64'shAAAA_AAAA, 64'sh5555_5555, 64'shAAAA_AAAA,
                                      64'sh5555_5555, 64'shAAAA_AAAA, 64'sh5555_5555,
                                      21'h0A_AAAA), 0, dummy});
        // Mostly large steps that overshoot the goal; one step is tiny.
        dir_rows.push_back('{make_req(0, 0, 0, 65536, 65536, 65536, 21'h1F_FFFF), 0, dummy});
        dir_rows.push_back('{make_req(131072, 0, -65536, 0, 0, 0, 1048576), 0, dummy});
        dir_rows.push_back('{make_req(65536, 65536, 65536, 0, 0, 0, 1), 0, dummy});
        dir_rows.push_back('{make_req(-1, 1, -1, 1, -1, 1, 21'h10_0000), 0, dummy});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            set_config(phase_st[p], phase_ms[p]);
            idle_mode = t_idle_mode'(p % 4);
            for (int n = 0; n < 240; n++) begin
                if (p == 2 && n == 20) hold_arm = 1'b1;
                // Within a phase, leave a calm stretch without idling.
                if (n == 180) idle_mode = IDLE_NONE;
                send_req(next_req(), 1'b0, dummy);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** critically_damped_smoother_3d: PASSED **");
        end else begin
            $display("** critically_damped_smoother_3d: FAILED **");
        end
        $finish;
    end

endmodule
